// ===== design/sjc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sjc_pkg;

    localparam int CENTER_DEPTH_DEF = 1024;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int COORD_W          = 31;
    localparam int CNT_W            = 16;
    localparam int SUM_W            = 32;

    localparam logic [CNT_W-1:0] SAT16   = '1;
    localparam logic [SUM_W-1:0] SAT_SUM = '1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    // One input request as it travels from the front to the back
    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] coord;
        logic               last_set;
        logic               last_cluster;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_COUNT,
        S_DIST,
        S_DWAIT,
        S_SQ,
        S_ACC,
        S_MSTART,
        S_MABS,
        S_MSQ,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== design/sjc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sjc_front (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire                            i_mode,
    input  wire  [sjc_pkg::COORD_W-1:0]    i_coordinate,
    input  wire                            i_last_of_set,
    input  wire                            i_last_of_cluster,
    output logic                           o_item_valid,
    output sjc_pkg::t_item                 o_item,
    input  wire                            i_item_pop
);

    sjc_pkg::t_item r_slot [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;
    sjc_pkg::t_item in_item;

    // Classify and pack the incoming request
    always_comb begin
        in_item.mode         = i_mode;
        in_item.coord        = i_coordinate;
        in_item.last_set     = i_last_of_set;
        in_item.last_cluster = i_last_of_cluster & i_last_of_set
                               & (i_mode == sjc_pkg::MODE_DATA);
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign push         = i_valid & o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign pop          = i_item_pop & o_item_valid;
    assign o_item       = r_slot[r_rp];

    // Hold requests in a two-entry queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

// ===== design/sjc_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sjc_divider #(
    parameter int DW = 41,
    parameter int VW = 17
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire  [DW-1:0] i_dividend,
    input  wire  [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   shifted;
    logic          ge;
    logic [VW:0]   diff;

    // One quotient bit per cycle, restoring
    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        ge      = (shifted >= {1'b0, r_dvs});
        diff    = shifted - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[VW-1:0] : shifted[VW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // Pulse done after the last quotient bit
            r_done <= ~i_start & r_busy & (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== design/sjc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sjc_back #(
    parameter int CENTER_DEPTH = sjc_pkg::CENTER_DEPTH_DEF,
    parameter int FRAC_BITS    = sjc_pkg::FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_item_valid,
    input  sjc_pkg::t_item               i_item,
    output logic                         o_item_pop,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [sjc_pkg::CNT_W-1:0]    o_overlap,
    output logic [sjc_pkg::CNT_W-1:0]    o_point_length,
    output logic [FRAC_BITS:0]           o_distance,
    output logic                         o_stats_valid,
    output logic [FRAC_BITS:0]           o_mean_abs,
    output logic [FRAC_BITS:0]           o_mean_square,
    output logic [sjc_pkg::CNT_W-1:0]    o_point_count,
    output logic                         o_center_overflow
);

    localparam int CW  = $clog2(CENTER_DEPTH + 1);
    localparam int AW  = (CENTER_DEPTH > 1) ? $clog2(CENTER_DEPTH) : 1;
    localparam int UW  = ((CW > sjc_pkg::CNT_W) ? CW : sjc_pkg::CNT_W) + 1;
    localparam int DW  = (UW + FRAC_BITS > sjc_pkg::SUM_W) ? UW + FRAC_BITS : sjc_pkg::SUM_W;
    localparam int VW  = UW;
    localparam int FW  = FRAC_BITS + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(CENTER_DEPTH);
    localparam logic [DW-1:0] ONE_Q   = DW'(1) << FRAC_BITS;

    logic [sjc_pkg::COORD_W-1:0] r_mem [CENTER_DEPTH];
    logic [sjc_pkg::COORD_W-1:0] r_q;

    sjc_pkg::t_state r_state, n_state;
    sjc_pkg::t_item  r_item;

    logic [CW-1:0]              r_count;
    logic [CW-1:0]              r_pos;
    logic [sjc_pkg::CNT_W-1:0]  r_ov;
    logic [sjc_pkg::CNT_W-1:0]  r_data;
    logic [sjc_pkg::CNT_W-1:0]  r_points;
    logic [sjc_pkg::SUM_W-1:0]  r_sum;
    logic [sjc_pkg::SUM_W-1:0]  r_sumsq;
    logic                       r_closed;
    logic                       r_oflow;
    logic [FW-1:0]              r_dist;
    logic [FW-1:0]              r_sq;
    logic [FW-1:0]              r_mabs;
    logic [FW-1:0]              r_msq;
    logic                       r_out_valid;

    logic          pop;
    logic          rd_en;
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [VW-1:0] div_divisor;
    logic          div_done;
    logic [DW-1:0] div_quo;
    logic          out_load;
    logic          has_entry;
    logic [CW-1:0] load_cnt;
    logic          load_full;
    logic [UW-1:0] uni_raw;
    logic [UW-1:0] uni;
    logic [2*FW-1:0] prod;
    logic [sjc_pkg::SUM_W:0] sum_add;
    logic [sjc_pkg::SUM_W:0] sumsq_add;
    logic [FW-1:0] mean_q;

    // Shared quotient unit for distance and means
    sjc_divider #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign has_entry = (r_pos < r_count);
    assign load_cnt  = r_closed ? '0 : r_count;
    assign load_full = (load_cnt >= DEPTH_C);
    assign out_load  = ~r_out_valid | i_ready;

    // Union and fixed-point arithmetic
    always_comb begin
        uni_raw = UW'(r_data) + UW'(r_count) - UW'(r_ov);
        uni     = (uni_raw == '0) ? UW'(1) : uni_raw;
        prod    = r_dist * r_dist;
        sum_add   = {1'b0, r_sum} + (sjc_pkg::SUM_W + 1)'(r_dist);
        sumsq_add = {1'b0, r_sumsq} + (sjc_pkg::SUM_W + 1)'(r_sq);
        mean_q    = (div_quo > ONE_Q) ? ONE_Q[FW-1:0] : div_quo[FW-1:0];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sjc_pkg::S_IDLE: begin
                if (i_item_valid && i_item.mode == sjc_pkg::MODE_DATA) begin
                    n_state = sjc_pkg::S_READ;
                end
            end
            sjc_pkg::S_READ:   n_state = has_entry ? sjc_pkg::S_CMP : sjc_pkg::S_COUNT;
            sjc_pkg::S_CMP:    n_state = (r_q < r_item.coord) ? sjc_pkg::S_READ
                                                              : sjc_pkg::S_COUNT;
            sjc_pkg::S_COUNT:  n_state = r_item.last_set ? sjc_pkg::S_DIST : sjc_pkg::S_IDLE;
            sjc_pkg::S_DIST:   n_state = sjc_pkg::S_DWAIT;
            sjc_pkg::S_DWAIT:  n_state = div_done ? sjc_pkg::S_SQ : sjc_pkg::S_DWAIT;
            sjc_pkg::S_SQ:     n_state = sjc_pkg::S_ACC;
            sjc_pkg::S_ACC:    n_state = r_item.last_cluster ? sjc_pkg::S_MSTART
                                                             : sjc_pkg::S_OUT;
            sjc_pkg::S_MSTART: n_state = sjc_pkg::S_MABS;
            sjc_pkg::S_MABS:   n_state = div_done ? sjc_pkg::S_MSQ : sjc_pkg::S_MABS;
            sjc_pkg::S_MSQ:    n_state = div_done ? sjc_pkg::S_OUT : sjc_pkg::S_MSQ;
            sjc_pkg::S_OUT:    n_state = out_load ? sjc_pkg::S_IDLE : sjc_pkg::S_OUT;
            default:           n_state = sjc_pkg::S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        pop          = 1'b0;
        rd_en        = 1'b0;
        div_start    = 1'b0;
        div_dividend = DW'(r_sum);
        div_divisor  = VW'(r_points);
        unique case (r_state)
            sjc_pkg::S_IDLE: pop = i_item_valid;
            sjc_pkg::S_READ: rd_en = has_entry;
            sjc_pkg::S_DIST: begin
                div_start    = 1'b1;
                div_dividend = DW'(uni - UW'(r_ov)) << FRAC_BITS;
                div_divisor  = uni;
            end
            sjc_pkg::S_MSTART: div_start = 1'b1;
            sjc_pkg::S_MABS: begin
                div_start    = div_done;
                div_dividend = DW'(r_sumsq);
            end
            default: begin
            end
        endcase
    end

    assign o_item_pop = pop;

    // Center store
    always_ff @(posedge i_clk) begin
        if (pop && i_item.mode == sjc_pkg::MODE_LOAD && !load_full) begin
            r_mem[load_cnt[AW-1:0]] <= i_item.coord;
        end
        if (rd_en) begin
            r_q <= r_mem[r_pos[AW-1:0]];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_item <= i_item;
        end
        if (r_state == sjc_pkg::S_DWAIT && div_done) begin
            r_dist <= div_quo[FW-1:0];
        end
        if (r_state == sjc_pkg::S_SQ) begin
            r_sq <= prod[FRAC_BITS +: FW];
        end
        if (r_state == sjc_pkg::S_ACC) begin
            r_mabs <= '0;
            r_msq  <= '0;
        end
        if (r_state == sjc_pkg::S_MABS && div_done) begin
            r_mabs <= mean_q;
        end
        if (r_state == sjc_pkg::S_MSQ && div_done) begin
            r_msq <= mean_q;
        end
        if (r_state == sjc_pkg::S_OUT && out_load) begin
            o_overlap         <= r_ov;
            o_point_length    <= r_data;
            o_distance        <= r_dist;
            o_stats_valid     <= r_item.last_cluster;
            o_mean_abs        <= r_mabs;
            o_mean_square     <= r_msq;
            o_point_count     <= r_points;
            o_center_overflow <= r_oflow;
        end
    end

    // Control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sjc_pkg::S_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_ov        <= '0;
            r_data      <= '0;
            r_points    <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_closed    <= 1'b1;
            r_oflow     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Load the output register or drop it once taken
            if (r_state == sjc_pkg::S_OUT && out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                sjc_pkg::S_IDLE: begin
                    if (pop) begin
                        if (i_item.mode == sjc_pkg::MODE_LOAD) begin
                            if (r_closed) begin
                                r_pos    <= '0;
                                r_ov     <= '0;
                                r_data   <= '0;
                                r_points <= '0;
                                r_sum    <= '0;
                                r_sumsq  <= '0;
                            end
                            r_count  <= load_full ? load_cnt : load_cnt + 1'b1;
                            r_oflow  <= (r_closed ? 1'b0 : r_oflow) | load_full;
                            r_closed <= i_item.last_set;
                        end else begin
                            r_closed <= 1'b1;
                        end
                    end
                end
                sjc_pkg::S_CMP: begin
                    if (r_q <= r_item.coord) begin
                        r_pos <= r_pos + 1'b1;
                    end
                    if (r_q == r_item.coord && r_ov != sjc_pkg::SAT16) begin
                        r_ov <= r_ov + 1'b1;
                    end
                end
                sjc_pkg::S_COUNT: begin
                    if (r_data != sjc_pkg::SAT16) begin
                        r_data <= r_data + 1'b1;
                    end
                end
                sjc_pkg::S_ACC: begin
                    r_sum   <= sum_add[sjc_pkg::SUM_W] ? sjc_pkg::SAT_SUM
                                                       : sum_add[sjc_pkg::SUM_W-1:0];
                    r_sumsq <= sumsq_add[sjc_pkg::SUM_W] ? sjc_pkg::SAT_SUM
                                                         : sumsq_add[sjc_pkg::SUM_W-1:0];
                    if (r_points != sjc_pkg::SAT16) begin
                        r_points <= r_points + 1'b1;
                    end
                end
                sjc_pkg::S_OUT: begin
                    if (out_load) begin
                        r_pos       <= '0;
                        r_ov        <= '0;
                        r_data      <= '0;
                        if (r_item.last_cluster) begin
                            r_points <= '0;
                            r_sum    <= '0;
                            r_sumsq  <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== design/sparse_jaccard_cluster_stats_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Jaccard distance statistics of a cluster against a stored center set.
// Send the center first as ascending coordinates with i_mode 0 (i_last_of_set
// on its final one), then each data point as ascending coordinates with
// i_mode 1. One result leaves per finished point: overlap, length, distance
// in Q1.FRAC_BITS, and on the cluster's last point the mean and mean squared
// distance. The merge reads each center entry it steps over through the
// registered port of the center memory. The end of a point runs a division
// in the bit-serial divider, whose dividend width DW is 33 at the defaults;
// the end of a cluster adds two more divisions. A two-entry input queue and
// an output register let the input and output sides stall independently. No
// clearing pass after reset.

module sparse_jaccard_cluster_stats_top #(
    parameter int CENTER_DEPTH = sjc_pkg::CENTER_DEPTH_DEF,
    parameter int FRAC_BITS    = sjc_pkg::FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire                          i_mode,
    input  wire  [sjc_pkg::COORD_W-1:0]  i_coordinate,
    input  wire                          i_last_of_set,
    input  wire                          i_last_of_cluster,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [sjc_pkg::CNT_W-1:0]    o_overlap,
    output logic [sjc_pkg::CNT_W-1:0]    o_point_length,
    output logic [FRAC_BITS:0]           o_distance,
    output logic                         o_stats_valid,
    output logic [FRAC_BITS:0]           o_mean_abs,
    output logic [FRAC_BITS:0]           o_mean_square,
    output logic [sjc_pkg::CNT_W-1:0]    o_point_count,
    output logic                         o_center_overflow
);

    logic           item_valid;
    logic           item_pop;
    sjc_pkg::t_item item;

    sjc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_mode            (i_mode),
        .i_coordinate      (i_coordinate),
        .i_last_of_set     (i_last_of_set),
        .i_last_of_cluster (i_last_of_cluster),
        .o_item_valid      (item_valid),
        .o_item            (item),
        .i_item_pop        (item_pop)
    );

    sjc_back #(
        .CENTER_DEPTH (CENTER_DEPTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item_valid      (item_valid),
        .i_item            (item),
        .o_item_pop        (item_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_overlap         (o_overlap),
        .o_point_length    (o_point_length),
        .o_distance        (o_distance),
        .o_stats_valid     (o_stats_valid),
        .o_mean_abs        (o_mean_abs),
        .o_mean_square     (o_mean_square),
        .o_point_count     (o_point_count),
        .o_center_overflow (o_center_overflow)
    );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH = sjc_pkg::CENTER_DEPTH_DEF;
    localparam int FB    = sjc_pkg::FRAC_BITS_DEF;
    localparam int CWID  = sjc_pkg::COORD_W;
    localparam int NW    = sjc_pkg::CNT_W;
    localparam int SW    = sjc_pkg::SUM_W;
    localparam logic [FB:0] ONE_Q = (FB + 1)'(1) << FB;

    // One finished point as it leaves the block
    typedef struct {
        logic [NW-1:0] overlap;
        logic [NW-1:0] length;
        logic [FB:0]   distance;
        logic          stats_valid;
        logic [FB:0]   mean_abs;
        logic [FB:0]   mean_square;
        logic [NW-1:0] count;
        logic          overflow;
    } t_point_stats;

    class jaccard_scoreboard;
        logic [CWID-1:0]    center[DEPTH];
        int unsigned        center_len;
        int unsigned        merge_pos;
        int unsigned        shared;
        int unsigned        point_len;
        int unsigned        points;
        logic [SW-1:0]      dist_sum;
        logic [SW-1:0]      sq_sum;
        bit                 center_done;
        bit                 dropped;
        t_point_stats       pending[$];
        int                 errors;

        function new();
            center_len = 0;
            dropped = 0;
            center_done = 1;
            errors = 0;
            clear_point();
            clear_cluster();
        endfunction

        function void clear_point();
            merge_pos = 0;
            shared = 0;
            point_len = 0;
        endfunction

        function void clear_cluster();
            points = 0;
            dist_sum = 0;
            sq_sum = 0;
        endfunction

        function logic [SW-1:0] add_clamped(logic [SW-1:0] a, longint unsigned b);
            longint unsigned s;
            s = longint'(a) + b;
            return (s > 64'hFFFF_FFFF) ? sjc_pkg::SAT_SUM : s[SW-1:0];
        endfunction

        function logic [FB:0] mean_clamped(logic [SW-1:0] s, int unsigned n);
            longint unsigned m;
            if (n == 0) return '0;
            m = longint'(s) / n;
            return (m > ONE_Q) ? ONE_Q : m[FB:0];
        endfunction

        // Advance the predicted state by one accepted request
        function void note_request(logic m, logic [CWID-1:0] c, logic ls, logic lc);
            longint unsigned uni, jdist, sq;
            t_point_stats    e;
            if (m == sjc_pkg::MODE_LOAD) begin
                if (center_done) begin
                    center_len = 0;
                    dropped = 0;
                    center_done = 0;
                    clear_point();
                    clear_cluster();
                end
                if (center_len < DEPTH) begin
                    center[center_len] = c;
                    center_len++;
                end else begin
                    dropped = 1;
                end
                if (ls) center_done = 1;
                return;
            end
            center_done = 1;
            while (merge_pos < center_len && center[merge_pos] < c) merge_pos++;
            if (merge_pos < center_len && center[merge_pos] == c) begin
                if (shared < 65535) shared++;
                merge_pos++;
            end
            if (point_len < 65535) point_len++;
            if (!ls) return;
            uni = point_len + center_len - shared;
            if (uni == 0) uni = 1;
            jdist = ((uni - shared) << FB) / uni;
            sq = (jdist * jdist) >> FB;
            dist_sum = add_clamped(dist_sum, jdist);
            sq_sum = add_clamped(sq_sum, sq);
            if (points < 65535) points++;
            e.overlap     = shared[NW-1:0];
            e.length      = point_len[NW-1:0];
            e.distance    = jdist[FB:0];
            e.stats_valid = lc;
            e.mean_abs    = lc ? mean_clamped(dist_sum, points) : '0;
            e.mean_square = lc ? mean_clamped(sq_sum, points) : '0;
            e.count       = points[NW-1:0];
            e.overflow    = dropped;
            pending.push_back(e);
            clear_point();
            if (lc) clear_cluster();
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        // Compare one result with the oldest expected point
        task check_result(t_point_stats r);
            t_point_stats e;
            if (pending.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            e = pending.pop_front();
            if (r.overlap !== e.overlap) report("overlap", r.overlap, e.overlap);
            if (r.length !== e.length) report("point_length", r.length, e.length);
            if (r.distance !== e.distance) report("distance", r.distance, e.distance);
            if (r.stats_valid !== e.stats_valid)
                report("stats_valid", r.stats_valid, e.stats_valid);
            if (r.mean_abs !== e.mean_abs) report("mean_abs", r.mean_abs, e.mean_abs);
            if (r.mean_square !== e.mean_square)
                report("mean_square", r.mean_square, e.mean_square);
            if (r.count !== e.count) report("point_count", r.count, e.count);
            if (r.overflow !== e.overflow)
                report("center_overflow", r.overflow, e.overflow);
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_mode;
    logic [CWID-1:0]    i_coordinate;
    logic               i_last_of_set;
    logic               i_last_of_cluster;
    logic               o_valid;
    logic               i_ready;
    logic [NW-1:0]      o_overlap;
    logic [NW-1:0]      o_point_length;
    logic [FB:0]        o_distance;
    logic               o_stats_valid;
    logic [FB:0]        o_mean_abs;
    logic [FB:0]        o_mean_square;
    logic [NW-1:0]      o_point_count;
    logic               o_center_overflow;

    sparse_jaccard_cluster_stats_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_mode            (i_mode),
        .i_coordinate      (i_coordinate),
        .i_last_of_set     (i_last_of_set),
        .i_last_of_cluster (i_last_of_cluster),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_overlap         (o_overlap),
        .o_point_length    (o_point_length),
        .o_distance        (o_distance),
        .o_stats_valid     (o_stats_valid),
        .o_mean_abs        (o_mean_abs),
        .o_mean_square     (o_mean_square),
        .o_point_count     (o_point_count),
        .o_center_overflow (o_center_overflow)
    );

    jaccard_scoreboard sb = new();
    int unsigned       send_idle_pct;
    int unsigned       recv_stall_pct;
    int unsigned       requests_sent;
    logic [CWID-1:0]   center_set[$];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Receiver side: stall at random
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        t_point_stats r;
        if (i_rst_n && o_valid && i_ready) begin
            r.overlap     = o_overlap;
            r.length      = o_point_length;
            r.distance    = o_distance;
            r.stats_valid = o_stats_valid;
            r.mean_abs    = o_mean_abs;
            r.mean_square = o_mean_square;
            r.count       = o_point_count;
            r.overflow    = o_center_overflow;
            sb.check_result(r);
        end
    end

    // Send one request and hold it until accepted
    task send_request(logic m, logic [CWID-1:0] c, logic ls, logic lc);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_mode            <= m;
        i_coordinate      <= c;
        i_last_of_set     <= ls;
        i_last_of_cluster <= lc;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(m, c, ls, lc);
        requests_sent++;
    endtask

    // Load a center of n ascending coordinates from base
    task load_center(logic [CWID-1:0] base, int n, int max_step);
        logic [CWID-1:0] v;
        v = base;
        center_set.delete();
        for (int k = 0; k < n; k++) begin
            center_set.push_back(v);
            send_request(sjc_pkg::MODE_LOAD, v, k == n - 1, 1'($urandom_range(1)));
            v = v + CWID'($urandom_range(1, max_step));
        end
    endtask

    // Stream one point: ascending coordinates that often hit the center
    task send_point(int n, bit last_point);
        logic [CWID-1:0] v;
        int idx;
        idx = 0;
        v = (center_set.size() > 0) ? center_set[0] - CWID'($urandom_range(0, 2))
                                    : CWID'($urandom());
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) begin
                v = CWID'($urandom());
            end else if (center_set.size() > idx && $urandom_range(2) != 0) begin
                idx = idx + int'($urandom_range(0, 1));
                if (idx >= center_set.size()) idx = center_set.size() - 1;
                if (center_set[idx] > v || k == 0) v = center_set[idx];
                else v = v + CWID'($urandom_range(1, 3));
                idx++;
            end else begin
                v = v + CWID'($urandom_range(1, 3));
            end
            send_request(sjc_pkg::MODE_DATA, v, k == n - 1,
                         (k == n - 1) ? last_point : 1'($urandom_range(1)));
        end
    endtask

    task wait_drained(int extra);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    initial begin
        int it;
        int np;
        int n;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_mode = sjc_pkg::MODE_LOAD;
        i_coordinate = '0;
        i_last_of_set = 1'b0;
        i_last_of_cluster = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        requests_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty center: a point before any load, extreme coordinates
        send_request(sjc_pkg::MODE_DATA, '0, 1'b0, 1'b1);
        send_request(sjc_pkg::MODE_DATA, '1, 1'b1, 1'b1);
        // Center at the top of the coordinate range, left open
        send_request(sjc_pkg::MODE_LOAD, 31'h7FFF_FFFD, 1'b0, 1'b1);
        send_request(sjc_pkg::MODE_LOAD, 31'h7FFF_FFFF, 1'b0, 1'b0);
        center_set = '{31'h7FFF_FFFD, 31'h7FFF_FFFF};
        // Data closes the center; exact match, then a descending point
        send_request(sjc_pkg::MODE_DATA, 31'h7FFF_FFFD, 1'b0, 1'b0);
        send_request(sjc_pkg::MODE_DATA, 31'h7FFF_FFFF, 1'b1, 1'b0);
        send_request(sjc_pkg::MODE_DATA, 31'h7FFF_FFFF, 1'b0, 1'b0);
        send_request(sjc_pkg::MODE_DATA, 31'h7FFF_FFFD, 1'b0, 1'b0);
        send_request(sjc_pkg::MODE_DATA, '0, 1'b1, 1'b1);
        // Small center from zero, full overlap and no overlap
        load_center('0, 3, 1);
        send_request(sjc_pkg::MODE_DATA, 31'd0, 1'b0, 1'b0);
        send_request(sjc_pkg::MODE_DATA, 31'd1, 1'b0, 1'b0);
        send_request(sjc_pkg::MODE_DATA, 31'd2, 1'b1, 1'b0);
        send_request(sjc_pkg::MODE_DATA, 31'h5555_5555, 1'b1, 1'b1);
        // Hold off until every result is back
        wait_drained(150);

        // Center larger than the store: entries dropped
        load_center(CWID'($urandom_range(0, 32'h7000_0000)), DEPTH + 6, 2);
        for (int p = 0; p < 3; p++) send_point(int'($urandom_range(1, 6)), p == 2);

        // Random clusters in four phases of send idling and receive stalls
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            it = 0;
            while (it < 100) begin
                if ($urandom_range(9) != 0)
                    load_center(CWID'($urandom_range(0, 32'h7FF0_0000)),
                                int'($urandom_range(1, 12)), int'($urandom_range(1, 4)));
                np = int'($urandom_range(1, 6));
                for (int p = 0; p < np; p++) begin
                    n = int'($urandom_range(1, 10));
                    send_point(n, p == np - 1);
                    it += n;
                end
            end
        end

        wait_drained(300);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
